>>> hw/rtl/splc_pkg.sv
`default_nettype none

package splc_pkg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_META,
        S_PROBE,
        S_LRU
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/splc_ram.sv
`default_nettype none

module splc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/serial_probe_lru_cache_lookup_top.sv
`default_nettype none
// An item passes through set reduction (only when SETS is below 2**SET_W), a metadata
// read, the probe, in which the tag memory is read one way per cycle, and the LRU update.
// One item is in work at a time, so a new item is taken only once the last one is done.
// A finished result waits in the output register while the next item is accepted.
// After reset a clearing pass sets up the valid and recency memory.

module serial_probe_lru_cache_lookup_top #(
    parameter int WAYS        = 8,
    parameter int SETS        = 512,
    parameter int TAG_W       = 13,
    parameter int SET_W       = 9,
    parameter int ADDR_BITS   = 22,
    parameter int OFFSET_BITS = 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [ADDR_BITS-1:0] address,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      hit,
    output logic      [2:0]           way_used,
    output logic      [3:0]           probe_count,
    output logic                      evicted
);

    import splc_pkg::*;

    localparam int WB       = $clog2(WAYS);
    localparam int SI       = $clog2(SETS);
    localparam int EXT_W    = ADDR_BITS + OFFSET_BITS + SET_W + TAG_W;
    localparam int ORD_W    = WAYS * WB;
    localparam int META_W   = WAYS + ORD_W;
    localparam int TDEPTH   = SETS * (1 << WB);
    localparam int CW       = $clog2(SET_W + 1);
    localparam bit NEED_MOD = (SETS < (1 << SET_W));

    state_t state_reg, state_next;
    logic [SI-1:0]       clr_reg, clr_next;
    logic [SI-1:0]       set_reg, set_next;
    logic [SET_W-1:0]    fsh_reg, fsh_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [WB-1:0]       w_reg, w_next;
    logic                inv_found_reg, inv_found_next;
    logic [WB-1:0]       inv_way_reg, inv_way_next;
    logic                hit_reg, hit_next;
    logic [WB-1:0]       chosen_reg, chosen_next;
    logic                evict_reg, evict_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_hit_reg, out_hit_next;
    logic [2:0]          out_way_reg, out_way_next;
    logic [3:0]          out_probe_reg, out_probe_next;
    logic                out_evict_reg, out_evict_next;

    logic [EXT_W-1:0]    addr_ext;
    logic [SI:0]         mod_trial;
    logic [META_W-1:0]   init_row;
    logic [META_W-1:0]   new_row;
    logic [WAYS-1:0]     valid_vec;
    logic [WB-1:0]       old_ord [WAYS];
    logic [WAYS-1:0]     seen;
    logic [WB+3:0]       probe_wide;
    logic [WB+2:0]       way_wide;
    logic                slot_free;

    logic                meta_wr_en;
    logic [SI-1:0]       meta_wr_addr;
    logic [META_W-1:0]   meta_wr_data;
    logic                meta_rd_en;
    logic [META_W-1:0]   meta_rdata;
    logic                tag_wr_en;
    logic                tag_rd_en;
    logic [WB-1:0]       tag_rd_way;
    logic [TAG_W-1:0]    tag_rdata;

    splc_ram #(
        .WIDTH(META_W),
        .DEPTH(SETS)
    ) u_meta_ram (
        .clk    (clk),
        .wr_en  (meta_wr_en),
        .wr_addr(meta_wr_addr),
        .wr_data(meta_wr_data),
        .rd_en  (meta_rd_en),
        .rd_addr(set_reg),
        .rd_data(meta_rdata)
    );

    splc_ram #(
        .WIDTH(TAG_W),
        .DEPTH(TDEPTH)
    ) u_tag_ram (
        .clk    (clk),
        .wr_en  (tag_wr_en),
        .wr_addr({set_reg, chosen_reg}),
        .wr_data(tag_reg),
        .rd_en  (tag_rd_en),
        .rd_addr({set_reg, tag_rd_way}),
        .rd_data(tag_rdata)
    );

    assign addr_ext  = EXT_W'(address);
    assign valid_vec = meta_rdata[ORD_W +: WAYS];
    assign mod_trial = {set_reg, fsh_reg[SET_W-1]};
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            init_row[i*WB +: WB] = WB'(i);
            old_ord[i]           = meta_rdata[i*WB +: WB];
        end
        init_row[ORD_W +: WAYS] = '0;

        seen[0] = 1'b0;
        for (int i = 1; i < WAYS; i++)
        begin
            seen[i] = seen[i-1] | (old_ord[i-1] == chosen_reg);
        end

        new_row[0 +: WB] = chosen_reg;
        for (int i = 1; i < WAYS; i++)
        begin
            new_row[i*WB +: WB] = seen[i] ? old_ord[i] : old_ord[i-1];
        end
        new_row[ORD_W +: WAYS] = valid_vec;
        new_row[ORD_W + int'(chosen_reg)] = 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        set_next       = set_reg;
        fsh_next       = fsh_reg;
        cnt_next       = cnt_reg;
        tag_next       = tag_reg;
        w_next         = w_reg;
        inv_found_next = inv_found_reg;
        inv_way_next   = inv_way_reg;
        hit_next       = hit_reg;
        chosen_next    = chosen_reg;
        evict_next     = evict_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_way_next   = out_way_reg;
        out_probe_next = out_probe_reg;
        out_evict_next = out_evict_reg;

        in_ready     = 1'b0;
        meta_wr_en   = 1'b0;
        meta_wr_addr = set_reg;
        meta_wr_data = new_row;
        meta_rd_en   = 1'b0;
        tag_wr_en    = 1'b0;
        tag_rd_en    = 1'b0;
        tag_rd_way   = '0;
        probe_wide   = (WB+4)'(chosen_reg) + (WB+4)'(1);
        way_wide     = (WB+3)'(chosen_reg);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                meta_wr_en   = 1'b1;
                meta_wr_addr = clr_reg;
                meta_wr_data = init_row;
                clr_next     = clr_reg + SI'(1);
                if (clr_reg == SI'(SETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    tag_next = addr_ext[OFFSET_BITS + SET_W +: TAG_W];
                    fsh_next = addr_ext[OFFSET_BITS +: SET_W];
                    cnt_next = '0;
                    if (NEED_MOD)
                    begin
                        set_next   = '0;
                        state_next = S_REDUCE;
                    end
                    else
                    begin
                        set_next   = SI'(addr_ext[OFFSET_BITS +: SET_W]);
                        state_next = S_META;
                    end
                end
            end
            S_REDUCE:
            begin
                if (mod_trial >= (SI+1)'(SETS))
                begin
                    set_next = SI'(mod_trial - (SI+1)'(SETS));
                end
                else
                begin
                    set_next = SI'(mod_trial);
                end
                fsh_next = fsh_reg << 1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(SET_W - 1))
                begin
                    state_next = S_META;
                end
            end
            S_META:
            begin
                meta_rd_en     = 1'b1;
                tag_rd_en      = 1'b1;
                tag_rd_way     = '0;
                w_next         = '0;
                inv_found_next = 1'b0;
                inv_way_next   = '0;
                state_next     = S_PROBE;
            end
            S_PROBE:
            begin
                if (valid_vec[w_reg] && (tag_rdata == tag_reg))
                begin
                    hit_next    = 1'b1;
                    chosen_next = w_reg;
                    evict_next  = 1'b0;
                    state_next  = S_LRU;
                end
                else
                begin
                    if (!valid_vec[w_reg] && !inv_found_reg)
                    begin
                        inv_found_next = 1'b1;
                        inv_way_next   = w_reg;
                    end
                    if (w_reg == WB'(WAYS - 1))
                    begin
                        hit_next   = 1'b0;
                        state_next = S_LRU;
                        if (inv_found_reg)
                        begin
                            chosen_next = inv_way_reg;
                            evict_next  = 1'b0;
                        end
                        else if (!valid_vec[w_reg])
                        begin
                            chosen_next = w_reg;
                            evict_next  = 1'b0;
                        end
                        else
                        begin
                            chosen_next = old_ord[WAYS-1];
                            evict_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        w_next     = w_reg + WB'(1);
                        tag_rd_en  = 1'b1;
                        tag_rd_way = w_reg + WB'(1);
                    end
                end
            end
            S_LRU:
            begin
                if (slot_free)
                begin
                    meta_wr_en     = 1'b1;
                    tag_wr_en      = !hit_reg;
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_reg;
                    out_way_next   = way_wide[2:0];
                    out_probe_next = hit_reg ? probe_wide[3:0] : 4'd0;
                    out_evict_next = evict_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg       <= set_next;
        fsh_reg       <= fsh_next;
        cnt_reg       <= cnt_next;
        tag_reg       <= tag_next;
        w_reg         <= w_next;
        inv_found_reg <= inv_found_next;
        inv_way_reg   <= inv_way_next;
        hit_reg       <= hit_next;
        chosen_reg    <= chosen_next;
        evict_reg     <= evict_next;
        out_hit_reg   <= out_hit_next;
        out_way_reg   <= out_way_next;
        out_probe_reg <= out_probe_next;
        out_evict_reg <= out_evict_next;
    end

    assign out_valid   = out_valid_reg;
    assign hit         = out_hit_reg;
    assign way_used    = out_way_reg;
    assign probe_count = out_probe_reg;
    assign evicted     = out_evict_reg;

endmodule

`default_nettype wire
